// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros : shared assertion macros for the curve sampler core
// clocked implication checks with an active-low asynchronous reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/bcs_pkg.sv -----
// ----------------------------------------------------------------------------
// bcs_pkg : shared constants for the bezier curve sampler
// command codes, fixed field widths and parameter defaults
// ----------------------------------------------------------------------------
`default_nettype none

package bcs_pkg;

	localparam int MAX_POINTS_DEF = 16;
	localparam int COORD_BITS_DEF = 20;

	localparam int T_BITS    = 17;
	localparam int STEP_BITS = 16;
	localparam int CMD_BITS  = 2;
	localparam int USER_BITS = CMD_BITS + 1;

	localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_EVAL  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_SWEEP = 2'd2;

	// 1.0 in Q1.16
	localparam logic [T_BITS-1:0]    T_ONE      = 17'h10000;
	localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd66;

endpackage

`default_nettype wire

// ----- rtl/core/bcs_ram.sv -----
// ----------------------------------------------------------------------------
// bcs_ram : generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/bcs_lerp.sv -----
// ----------------------------------------------------------------------------
// bcs_lerp : pipelined lerp unit for both axes
// a + ((b - a) * t) >>> 16: registered difference, registered product, sum
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_lerp #(
	parameter int COORD_BITS = 20,
	parameter int AW = 4,
	localparam int PTW = 2 * COORD_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [AW-1:0]              in_addr,
	input  logic [PTW-1:0]             pt_a,
	input  logic [PTW-1:0]             pt_b,
	input  logic [bcs_pkg::T_BITS-1:0] t,
	output logic                       wr_valid,
	output logic [AW-1:0]              wr_addr,
	output logic [PTW-1:0]             wr_data,
	output logic                       busy
);

	import bcs_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int PW = CB + T_BITS + 2;

	logic                 v_s2;
	logic                 v_s3;
	logic [AW-1:0]        addr_s2;
	logic [AW-1:0]        addr_s3;
	logic [PTW-1:0]       a_s2;
	logic [PTW-1:0]       a_s3;
	logic signed [CB:0]   dx_s2;
	logic signed [CB:0]   dy_s2;
	logic signed [PW-1:0] px_s3;
	logic signed [PW-1:0] py_s3;
	logic signed [T_BITS:0] t_mul;
	logic [CB-1:0]        rx;
	logic [CB-1:0]        ry;

	assign t_mul = signed'({1'b0, t});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2 <= in_addr;
		a_s2    <= pt_a;
		dx_s2   <= signed'({pt_b[CB-1], pt_b[CB-1:0]}) - signed'({pt_a[CB-1], pt_a[CB-1:0]});
		dy_s2   <= signed'({pt_b[PTW-1], pt_b[PTW-1:CB]})
			- signed'({pt_a[PTW-1], pt_a[PTW-1:CB]});
		addr_s3 <= addr_s2;
		a_s3    <= a_s2;
		px_s3   <= dx_s2 * t_mul;
		py_s3   <= dy_s2 * t_mul;
	end

	// the result lies between a and b, so the low bits of the sum are exact
	assign rx = a_s3[CB-1:0] + px_s3[CB+15:16];
	assign ry = a_s3[PTW-1:CB] + py_s3[CB+15:16];

	assign wr_valid = v_s3;
	assign wr_addr  = addr_s3;
	assign wr_data  = {ry, rx};
	assign busy     = v_s2 | v_s3;

endmodule

`default_nettype wire

// ----- rtl/core/bezier_curve_sampler.sv -----
// ----------------------------------------------------------------------------
// bezier_curve_sampler : de casteljau bezier curve evaluation and sweep
// stores control points, evaluates at t and emits a sampled polyline
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one request per handshake: s_tuser[1:0] command,
//   s_tuser[2] start_set, s_tdata holds point_x, point_y, param_t.
//   m_* channel returns one result for evaluate and sweep requests:
//   m_tdata holds curve_x, curve_y, m_tlast marks the final sweep point,
//   m_tuser flags too few stored points.
//   cfg_* writes sample_step; it is always ready; the user must see that it
//   is written only when idle, which the block itself does not enforce.
// Operation:
//   a curve evaluation with N stored points runs the lerp pipeline once per
//   level; each level streams through the shared read port of the point
//   memories and the lerp stages, and the next level starts only after the
//   last write has landed. sweep endpoints are read from the control points.
//   s_tready is high only when no request is in progress.
// Reset:
//   clears point count and sweep position, sample_step returns to 66; the
//   point memories need no clearing since only written entries are read.
// Stalls:
//   a finished result waits in the output register while m_tready is low;
//   the block holds the request until the result can be loaded.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bezier_curve_sampler #(
	parameter int MAX_POINTS = bcs_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = bcs_pkg::COORD_BITS_DEF,
	localparam int IN_W  = ((2 * COORD_BITS + bcs_pkg::T_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bcs_pkg::STEP_BITS-1:0] cfg_data,   // sample_step
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [IN_W-1:0]               s_tdata,    // point_x, point_y, param_t
	input  logic [bcs_pkg::USER_BITS-1:0] s_tuser,    // command, start_set
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [OUT_W-1:0]              m_tdata,    // curve_x, curve_y
	output logic                          m_tlast,
	output logic                          m_tuser     // error
);

	import bcs_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int PTW = 2 * CB;
	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LEVEL = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_RDRES = 3'd3;
	localparam logic [2:0] ST_CAP   = 3'd4;

	localparam logic [1:0] SRC_CTRL = 2'd0;
	localparam logic [1:0] SRC_WORK = 2'd1;
	localparam logic [1:0] SRC_ERR  = 2'd2;

	logic [2:0]           state_q;
	logic [CW-1:0]        count_q;
	logic [T_BITS-1:0]    sweep_t_q;
	logic                 phase_q;
	logic [STEP_BITS-1:0] step_q;
	logic [T_BITS-1:0]    t_q;
	logic [CW-1:0]        lvl_n_q;
	logic                 first_lvl_q;
	logic [AW-1:0]        rd_i_q;
	logic [1:0]           res_src_q;
	logic [AW-1:0]        res_addr_q;
	logic                 res_last_q;

	logic                 rd_v_s1;
	logic [AW-1:0]        rd_idx_s1;
	logic                 rd_ctrl_s1;
	logic [PTW-1:0]       prev_q;

	logic                 out_valid_q;
	logic [CB-1:0]        out_x_q;
	logic [CB-1:0]        out_y_q;
	logic                 out_last_q;
	logic                 out_err_q;

	logic                 s_accept;
	logic [CMD_BITS-1:0]  cmd;
	logic                 start_set;
	logic [CB-1:0]        in_x;
	logic [CB-1:0]        in_y;
	logic [T_BITS-1:0]    in_t;
	logic [T_BITS-1:0]    t_sat;
	logic [T_BITS-1:0]    step_eff;
	logic                 few_points;
	logic                 out_free;

	logic                 ctrl_we;
	logic [AW-1:0]        ctrl_waddr;
	logic                 ctrl_re;
	logic                 work_re;
	logic [AW-1:0]        rd_addr;
	logic [PTW-1:0]       ctrl_rdata;
	logic [PTW-1:0]       work_rdata;
	logic [PTW-1:0]       s1_data;
	logic [PTW-1:0]       res_data;

	logic                 lerp_in_v;
	logic                 lerp_wr_v;
	logic [AW-1:0]        lerp_waddr;
	logic [PTW-1:0]       lerp_wdata;
	logic                 lerp_busy;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;

	assign cmd       = s_tuser[CMD_BITS-1:0];
	assign start_set = s_tuser[CMD_BITS];
	assign in_x      = s_tdata[CB-1:0];
	assign in_y      = s_tdata[PTW-1:CB];
	assign in_t      = s_tdata[PTW+T_BITS-1:PTW];

	assign t_sat      = (in_t > T_ONE) ? T_ONE : in_t;
	assign step_eff   = (step_q == '0) ? T_BITS'(1) : T_BITS'(step_q);
	assign few_points = (count_q < CW'(2));
	assign out_free   = !out_valid_q || m_tready;

	// point store writes
	assign ctrl_we    = s_accept && (cmd == CMD_LOAD) && (start_set || count_q < CW'(MAX_POINTS));
	assign ctrl_waddr = start_set ? '0 : count_q[AW-1:0];

	// shared read port: level walk or result fetch
	assign rd_addr = (state_q == ST_LEVEL) ? rd_i_q : res_addr_q;
	assign ctrl_re = ((state_q == ST_LEVEL) && first_lvl_q)
		|| ((state_q == ST_RDRES) && (res_src_q == SRC_CTRL));
	assign work_re = ((state_q == ST_LEVEL) && !first_lvl_q)
		|| ((state_q == ST_RDRES) && (res_src_q == SRC_WORK));

	bcs_ram #(
		.WIDTH (PTW),
		.DEPTH (MAX_POINTS)
	) u_ctrl_ram (
		.clk   (clk),
		.we    (ctrl_we),
		.waddr (ctrl_waddr),
		.wdata ({in_y, in_x}),
		.re    (ctrl_re),
		.raddr (rd_addr),
		.rdata (ctrl_rdata)
	);

	bcs_ram #(
		.WIDTH (PTW),
		.DEPTH (MAX_POINTS)
	) u_work_ram (
		.clk   (clk),
		.we    (lerp_wr_v),
		.waddr (lerp_waddr),
		.wdata (lerp_wdata),
		.re    (work_re),
		.raddr (rd_addr),
		.rdata (work_rdata)
	);

	assign s1_data   = rd_ctrl_s1 ? ctrl_rdata : work_rdata;
	// the first point of a level only primes the previous-point register
	assign lerp_in_v = rd_v_s1 && (rd_idx_s1 != '0);

	bcs_lerp #(
		.COORD_BITS (COORD_BITS),
		.AW         (AW)
	) u_lerp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (lerp_in_v),
		.in_addr  (rd_idx_s1 - AW'(1)),
		.pt_a     (prev_q),
		.pt_b     (s1_data),
		.t        (t_q),
		.wr_valid (lerp_wr_v),
		.wr_addr  (lerp_waddr),
		.wr_data  (lerp_wdata),
		.busy     (lerp_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sweep_t_q   <= '0;
			phase_q     <= 1'b0;
			t_q         <= '0;
			lvl_n_q     <= '0;
			first_lvl_q <= 1'b0;
			rd_i_q      <= '0;
			res_src_q   <= SRC_ERR;
			res_addr_q  <= '0;
			res_last_q  <= 1'b0;
			rd_v_s1     <= 1'b0;
			rd_ctrl_s1  <= 1'b0;
		end else begin
			rd_v_s1    <= (state_q == ST_LEVEL);
			rd_ctrl_s1 <= first_lvl_q;
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						res_last_q <= 1'b0;
						lvl_n_q    <= count_q;
						first_lvl_q <= 1'b1;
						rd_i_q     <= '0;
						case (cmd)
							CMD_LOAD: begin
								if (start_set) begin
									count_q   <= CW'(1);
									sweep_t_q <= '0;
									phase_q   <= 1'b0;
								end else if (count_q < CW'(MAX_POINTS)) begin
									count_q <= count_q + CW'(1);
								end
							end
							CMD_EVAL: begin
								if (few_points) begin
									res_src_q <= SRC_ERR;
									state_q   <= ST_CAP;
								end else begin
									t_q     <= t_sat;
									state_q <= ST_LEVEL;
								end
							end
							CMD_SWEEP: begin
								if (few_points) begin
									sweep_t_q <= '0;
									phase_q   <= 1'b0;
									res_src_q <= SRC_ERR;
									state_q   <= ST_CAP;
								end else if (!phase_q) begin
									phase_q    <= 1'b1;
									sweep_t_q  <= step_eff;
									res_src_q  <= SRC_CTRL;
									res_addr_q <= '0;
									state_q    <= ST_RDRES;
								end else if (sweep_t_q <= T_ONE - step_eff) begin
									t_q       <= sweep_t_q;
									sweep_t_q <= sweep_t_q + step_eff;
									state_q   <= ST_LEVEL;
								end else begin
									// end of sweep: last control point, then restart
									phase_q    <= 1'b0;
									sweep_t_q  <= '0;
									res_src_q  <= SRC_CTRL;
									res_addr_q <= AW'(count_q - CW'(1));
									res_last_q <= 1'b1;
									state_q    <= ST_RDRES;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_LEVEL: begin
					rd_i_q <= rd_i_q + AW'(1);
					if (CW'(rd_i_q) == lvl_n_q - CW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// wait until every write of this level has landed
					if (!rd_v_s1 && !lerp_busy) begin
						if (lvl_n_q == CW'(2)) begin
							res_src_q  <= SRC_WORK;
							res_addr_q <= '0;
							state_q    <= ST_RDRES;
						end else begin
							lvl_n_q     <= lvl_n_q - CW'(1);
							first_lvl_q <= 1'b0;
							rd_i_q      <= '0;
							state_q     <= ST_LEVEL;
						end
					end
				end
				ST_RDRES: begin
					state_q <= ST_CAP;
				end
				ST_CAP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_i_q;
		if (rd_v_s1) begin
			prev_q <= s1_data;
		end
	end

	always_comb begin
		case (res_src_q)
			SRC_CTRL: res_data = ctrl_rdata;
			SRC_WORK: res_data = work_rdata;
			default:  res_data = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_CAP) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_CAP) && out_free) begin
			out_x_q    <= res_data[CB-1:0];
			out_y_q    <= res_data[PTW-1:CB];
			out_last_q <= res_last_q;
			out_err_q  <= (res_src_q == SRC_ERR);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_y_q, out_x_q});
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

	`CHK_IMPLY(a_ready_quiet, clk, arst_n, s_tready, !rd_v_s1 && !lerp_busy, "request taken while lerp pipeline busy")
	`CHK_IMPLY(a_level_size, clk, arst_n, state_q == ST_LEVEL, lvl_n_q >= CW'(2), "level walk with fewer than two points")
	`CHK_IMPLY(a_wr_range, clk, arst_n, lerp_wr_v, (CW'(lerp_waddr) + CW'(1)) < lvl_n_q, "lerp write beyond current level")
	`CHK_NEXT(a_cap_load, clk, arst_n, (state_q == ST_CAP) && out_free, m_tvalid && s_tready, "result not loaded on capture")

endmodule

`default_nettype wire
